/* sv/ccq_pkg.sv */
// Shared widths, operation codes and storage control type for the coalescing circular queue.
package ccq_pkg;

    // Field widths of the command and result transfers.
    localparam int KEY_W    = 32;
    localparam int QTY_W    = 31;
    localparam int IN_QTY_W = 16;
    localparam int PRICE_W  = 32;
    localparam int SLOT_W   = 5;
    localparam int OCC_W    = 6;

    // Largest quantity an entry can hold; merges saturate here.
    localparam logic [QTY_W-1:0] QTY_MAX = {QTY_W{1'b1}};

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Control from the sequencer to the entry store.
    typedef struct packed {
        logic rd_en;     // register the entry at the read address
        logic wr_entry;  // write key, quantity and price at the write address
        logic wr_qty;    // write the quantity alone at the write address
    } ccq_mem_ctl_t;

endpackage

/* sv/coalescing_circular_queue_top.sv */
// Coalescing circular queue: command sequencer, ring pointers and result registers.
//
// A command is transferred on a rising edge where start is high and busy is low; the
// fields op, item_key, item_qty, item_price and slot are sampled on that edge. busy
// stays high until the result has been shown. Exactly one result follows each command:
// it is on the result ports for one cycle marked by done, and the receiver must take
// it then, as it cannot hold results off.
// Steps, counted from the command edge to the done cycle:
//   insert with entries held: key search, then append when no key matches or merge
//   on a match, then head read; insert into an empty queue: append, then head read.
//   remove, read slot, insert refused when full and any other op: entry read only.
// busy falls in the cycle after done. The key search walks the held entries one per
// cycle through the single read port of the entry store, which sets the insert time.
// Reset clears the head pointer and the entry count, leaving the queue empty; the
// entry store is not cleared, and a slot never written reads back undefined contents.
module coalescing_circular_queue_top #(
    parameter int DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  op,
    input  logic [ccq_pkg::KEY_W-1:0]   item_key,
    input  logic [ccq_pkg::IN_QTY_W-1:0] item_qty,
    input  logic [ccq_pkg::PRICE_W-1:0] item_price,
    input  logic [ccq_pkg::SLOT_W-1:0]  slot,
    output logic                        done,
    output logic                        accepted,
    output logic                        merged,
    output logic [ccq_pkg::OCC_W-1:0]   occupancy,
    output logic                        is_empty,
    output logic                        is_full,
    output logic [ccq_pkg::KEY_W-1:0]   out_key,
    output logic [ccq_pkg::QTY_W-1:0]   out_qty,
    output logic [ccq_pkg::PRICE_W-1:0] out_price
);
    import ccq_pkg::*;

    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [SW-1:0] LAST_SLOT = SW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [SW:0]   DEPTH_X   = (SW+1)'(DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_MERGE  = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [SW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [SW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       iss_reg, iss_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic                acc_reg, acc_next;
    logic                merged_reg, merged_next;
    logic                zero_reg, zero_next;

    logic [1:0]          op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [IN_QTY_W-1:0] qty_in_reg, qty_in_next;
    logic [PRICE_W-1:0]  price_reg, price_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SW-1:0]       cmp_slot_reg, cmp_slot_next;
    logic [QTY_W-1:0]    hit_qty_reg, hit_qty_next;

    ccq_mem_ctl_t        mem_ctl;
    logic [SW-1:0]       rd_addr;
    logic [SW-1:0]       wr_addr;
    logic [QTY_W-1:0]    wr_qty;
    logic [KEY_W-1:0]    rd_key;
    logic [QTY_W-1:0]    rd_qty;
    logic [PRICE_W-1:0]  rd_price;

    logic [SW:0]         tail_sum;
    logic [SW-1:0]       tail_slot;
    logic [QTY_W:0]      merge_sum;
    logic [QTY_W-1:0]    merge_qty;
    logic                slot_in_range;
    logic [SW-1:0]       slot_idx;
    logic [SW:0]         slot_off;
    logic [SW-1:0]       ptr_inc;

    // Entry store.
    ccq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk      (clk),
        .ctl      (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_key   (key_reg),
        .wr_qty   (wr_qty),
        .wr_price (price_reg),
        .rd_key   (rd_key),
        .rd_qty   (rd_qty),
        .rd_price (rd_price)
    );

    // Ring arithmetic: tail slot, search pointer step and offset of a read slot from head.
    always_comb
    begin
        tail_sum  = (SW+1)'(head_reg) + (SW+1)'(count_reg);
        tail_slot = (tail_sum >= DEPTH_X) ? SW'(tail_sum - DEPTH_X) : SW'(tail_sum);
        ptr_inc   = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;

        slot_in_range = (32'(slot_reg) < 32'(DEPTH));
        slot_idx      = SW'(slot_reg);
        if (slot_idx >= head_reg)
        begin
            slot_off = (SW+1)'(slot_idx) - (SW+1)'(head_reg);
        end
        else
        begin
            slot_off = (SW+1)'(slot_idx) + DEPTH_X - (SW+1)'(head_reg);
        end
    end

    // Saturating merge of the incoming quantity into the matched entry.
    always_comb
    begin
        merge_sum = (QTY_W+1)'(hit_qty_reg) + (QTY_W+1)'(qty_in_reg);
        merge_qty = merge_sum[QTY_W] ? QTY_MAX : merge_sum[QTY_W-1:0];
    end

    // Command sequencer.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        iss_next       = iss_reg;
        cmp_valid_next = cmp_valid_reg;
        acc_next       = acc_reg;
        merged_next    = merged_reg;
        zero_next      = zero_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        qty_in_next    = qty_in_reg;
        price_next     = price_reg;
        slot_next      = slot_reg;
        cmp_slot_next  = cmp_slot_reg;
        hit_qty_next   = hit_qty_reg;
        mem_ctl        = '0;
        rd_addr        = ptr_reg;
        wr_addr        = tail_slot;
        wr_qty         = QTY_W'(qty_in_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = op;
                    key_next    = item_key;
                    qty_in_next = item_qty;
                    price_next  = item_price;
                    slot_next   = slot;
                    acc_next    = 1'b0;
                    merged_next = 1'b0;
                    priority if (op == OP_INSERT)
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            state_next = S_READ;
                        end
                        else
                        begin
                            acc_next       = 1'b1;
                            ptr_next       = head_reg;
                            iss_next       = '0;
                            cmp_valid_next = 1'b0;
                            state_next     = (count_reg == '0) ? S_APPEND : S_SEARCH;
                        end
                    end
                    else if (op == OP_REMOVE)
                    begin
                        if (count_reg != '0)
                        begin
                            head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                            acc_next   = 1'b1;
                        end
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_SEARCH:
            begin
                // Compare the entry read last cycle while the next one is fetched.
                priority if (cmp_valid_reg && (rd_key == key_reg))
                begin
                    hit_qty_next = rd_qty;
                    merged_next  = 1'b1;
                    state_next   = S_MERGE;
                end
                else if (iss_reg < count_reg)
                begin
                    mem_ctl.rd_en  = 1'b1;
                    rd_addr        = ptr_reg;
                    cmp_slot_next  = ptr_reg;
                    ptr_next       = ptr_inc;
                    iss_next       = iss_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end

            S_MERGE:
            begin
                mem_ctl.wr_qty = 1'b1;
                wr_addr        = cmp_slot_reg;
                wr_qty         = merge_qty;
                state_next     = S_READ;
            end

            S_APPEND:
            begin
                mem_ctl.wr_entry = 1'b1;
                wr_addr          = tail_slot;
                count_next       = count_reg + 1'b1;
                state_next       = S_READ;
            end

            S_READ:
            begin
                // Fetch the entry shown with the result: the read slot, or the head.
                if (op_reg == OP_READ)
                begin
                    if (slot_in_range)
                    begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = slot_idx;
                        acc_next      = (slot_off < (SW+1)'(count_reg));
                        zero_next     = 1'b0;
                    end
                    else
                    begin
                        acc_next  = 1'b0;
                        zero_next = 1'b1;
                    end
                end
                else
                begin
                    mem_ctl.rd_en = (count_reg != '0);
                    rd_addr       = head_reg;
                    zero_next     = (count_reg == '0);
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            iss_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            acc_reg       <= 1'b0;
            merged_reg    <= 1'b0;
            zero_reg      <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            iss_reg       <= iss_next;
            cmp_valid_reg <= cmp_valid_next;
            acc_reg       <= acc_next;
            merged_reg    <= merged_next;
            zero_reg      <= zero_next;
        end
    end

    // Command payload and search registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        qty_in_reg   <= qty_in_next;
        price_reg    <= price_next;
        slot_reg     <= slot_next;
        cmp_slot_reg <= cmp_slot_next;
        hit_qty_reg  <= hit_qty_next;
    end

    // Result transfer.
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign accepted  = acc_reg;
    assign merged    = merged_reg;
    assign occupancy = OCC_W'(count_reg);
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == FULL_CNT);
    assign out_key   = zero_reg ? '0 : rd_key;
    assign out_qty   = zero_reg ? '0 : rd_qty;
    assign out_price = zero_reg ? '0 : rd_price;

endmodule

/* sv/ccq_store.sv */
// Entry store of the coalescing circular queue: one write port and one registered read port.
module ccq_store #(
    parameter int DEPTH = 32,
    parameter int SW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  ccq_pkg::ccq_mem_ctl_t       ctl,
    input  logic [SW-1:0]               rd_addr,
    input  logic [SW-1:0]               wr_addr,
    input  logic [ccq_pkg::KEY_W-1:0]   wr_key,
    input  logic [ccq_pkg::QTY_W-1:0]   wr_qty,
    input  logic [ccq_pkg::PRICE_W-1:0] wr_price,
    output logic [ccq_pkg::KEY_W-1:0]   rd_key,
    output logic [ccq_pkg::QTY_W-1:0]   rd_qty,
    output logic [ccq_pkg::PRICE_W-1:0] rd_price
);
    import ccq_pkg::*;

    logic [KEY_W-1:0]   key_mem   [DEPTH];
    logic [QTY_W-1:0]   qty_mem   [DEPTH];
    logic [PRICE_W-1:0] price_mem [DEPTH];

    // Key and price are written only when a new entry is appended.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_entry)
        begin
            key_mem[wr_addr]   <= wr_key;
            price_mem[wr_addr] <= wr_price;
        end
    end

    // The quantity is written on an append and on a merge.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_entry || ctl.wr_qty)
        begin
            qty_mem[wr_addr] <= wr_qty;
        end
    end

    // Registered read of one whole entry.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_key   <= key_mem[rd_addr];
            rd_qty   <= qty_mem[rd_addr];
            rd_price <= price_mem[rd_addr];
        end
    end

endmodule
